[hw/rtl/swm_pkg.sv]
package swm_pkg;

    localparam int MAX_CHARS_DEF = 256;
    localparam int CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

    // operation codes of an input item
    localparam logic [1:0] OP_APPEND_NAME = 2'd0;
    localparam logic [1:0] OP_APPEND_PAT  = 2'd1;
    localparam logic [1:0] OP_MATCH       = 2'd2;

    // datapath commands
    localparam logic [3:0] DP_NOP        = 4'd0;
    localparam logic [3:0] DP_APP_NAME   = 4'd1;
    localparam logic [3:0] DP_APP_PAT    = 4'd2;
    localparam logic [3:0] DP_CLEAR      = 4'd3;
    localparam logic [3:0] DP_SCAN_INIT  = 4'd4;
    localparam logic [3:0] DP_SCAN_STEP  = 4'd5;
    localparam logic [3:0] DP_PRE_INIT   = 4'd6;
    localparam logic [3:0] DP_SUF_INIT   = 4'd7;
    localparam logic [3:0] DP_ADV        = 4'd8;
    localparam logic [3:0] DP_SEG_INIT   = 4'd9;
    localparam logic [3:0] DP_PINC       = 4'd10;
    localparam logic [3:0] DP_SEG_START  = 4'd11;
    localparam logic [3:0] DP_SEG_DONE   = 4'd12;
    localparam logic [3:0] DP_RETRY      = 4'd13;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CHAR_W-1:0] char_value;
    } t_cmd;

    typedef struct packed {
        logic matched;
        logic status;
    } t_res;

    typedef struct packed {
        logic [3:0]        op;
        logic [CHAR_W-1:0] wdata;
    } t_dp_ctl;

    typedef struct packed {
        logic ovf;
        logic name_empty;
        logic pat_empty;
        logic pat_star;
        logic chars_eq;
        logic p_last;
        logic pre_last;
        logic first_zero;
        logic have_star;
        logic have_nonstar;
        logic short_fail;
        logic suf_zero;
        logic skip_done;
        logic at_hi;
    } t_dp_stat;

endpackage

[hw/rtl/swm_ram.sv]
module swm_ram #(
    parameter int WIDTH = swm_pkg::CHAR_W,
    parameter int DEPTH = swm_pkg::MAX_CHARS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/swm_dp.sv]
module swm_dp #(
    parameter int MAX_CHARS = swm_pkg::MAX_CHARS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swm_pkg::t_dp_ctl  i_ctl,
    output swm_pkg::t_dp_stat o_stat
);
    import swm_pkg::*;

    localparam int IW = $clog2(MAX_CHARS);
    localparam int LW = $clog2(MAX_CHARS + 1);

    logic [LW-1:0] r_nlen, r_plen;
    logic          r_ovf;
    logic [LW-1:0] r_pidx, r_nidx;
    logic [LW-1:0] r_first, r_last;
    logic          r_have_star, r_have_nonstar;
    logic [LW-1:0] r_seg_a, r_k, r_hi;

    logic [CHAR_W-1:0] name_q, pat_q;
    logic [LW-1:0]     suf;
    logic [LW:0]       pre_sum;
    logic              name_full, pat_full;
    logic              name_we, pat_we;

    assign name_full = (r_nlen == LW'(MAX_CHARS));
    assign pat_full  = (r_plen == LW'(MAX_CHARS));
    assign name_we   = (i_ctl.op == DP_APP_NAME) && !name_full;
    assign pat_we    = (i_ctl.op == DP_APP_PAT) && !pat_full;

    swm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (r_nlen[IW-1:0]),
        .i_wdata (i_ctl.wdata),
        .i_raddr (r_nidx[IW-1:0]),
        .o_rdata (name_q)
    );

    swm_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_plen[IW-1:0]),
        .i_wdata (i_ctl.wdata),
        .i_raddr (r_pidx[IW-1:0]),
        .o_rdata (pat_q)
    );

    // literal suffix length after the last star
    assign suf     = r_plen - r_last - LW'(1);
    assign pre_sum = {1'b0, r_first} + {1'b0, suf};

    always_comb begin
        o_stat.ovf          = r_ovf;
        o_stat.name_empty   = (r_nlen == '0);
        o_stat.pat_empty    = (r_plen == '0);
        o_stat.pat_star     = (pat_q == STAR_CHAR);
        o_stat.chars_eq     = (name_q == pat_q);
        o_stat.p_last       = ((r_pidx + LW'(1)) == r_plen);
        o_stat.pre_last     = ((r_pidx + LW'(1)) == r_first);
        o_stat.first_zero   = (r_first == '0);
        o_stat.have_star    = r_have_star;
        o_stat.have_nonstar = r_have_nonstar;
        o_stat.short_fail   = r_have_star ? ({1'b0, r_nlen} < pre_sum) : (r_nlen != r_plen);
        o_stat.suf_zero     = (suf == '0);
        o_stat.skip_done    = (r_pidx >= r_last);
        o_stat.at_hi        = (r_nidx >= r_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nlen <= '0;
            r_plen <= '0;
            r_ovf  <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                DP_APP_NAME: begin
                    if (name_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_nlen <= r_nlen + LW'(1);
                    end
                end
                DP_APP_PAT: begin
                    if (pat_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_plen <= r_plen + LW'(1);
                    end
                end
                DP_CLEAR: begin
                    r_nlen <= '0;
                    r_plen <= '0;
                    r_ovf  <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // walk registers, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            DP_SCAN_INIT: begin
                r_pidx         <= '0;
                r_first        <= r_plen;
                r_last         <= '0;
                r_have_star    <= 1'b0;
                r_have_nonstar <= 1'b0;
            end
            DP_SCAN_STEP: begin
                if (pat_q == STAR_CHAR) begin
                    if (!r_have_star) begin
                        r_first <= r_pidx;
                    end
                    r_last      <= r_pidx;
                    r_have_star <= 1'b1;
                end else begin
                    r_have_nonstar <= 1'b1;
                end
                r_pidx <= r_pidx + LW'(1);
            end
            DP_PRE_INIT: begin
                r_pidx <= '0;
                r_nidx <= '0;
            end
            DP_SUF_INIT: begin
                r_pidx <= r_last + LW'(1);
                r_nidx <= r_nlen - suf;
            end
            DP_ADV: begin
                r_pidx <= r_pidx + LW'(1);
                r_nidx <= r_nidx + LW'(1);
            end
            DP_SEG_INIT: begin
                r_pidx <= r_first;
                r_k    <= r_first;
                r_hi   <= r_nlen - suf;
            end
            DP_PINC: begin
                r_pidx <= r_pidx + LW'(1);
            end
            DP_SEG_START: begin
                r_seg_a <= r_pidx;
                r_nidx  <= r_k;
            end
            DP_SEG_DONE: begin
                r_k <= r_nidx;
            end
            DP_RETRY: begin
                r_k    <= r_k + LW'(1);
                r_nidx <= r_k + LW'(1);
                r_pidx <= r_seg_a;
            end
            default: begin
            end
        endcase
    end

    a_nlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nlen <= LW'(MAX_CHARS)) && (r_plen <= LW'(MAX_CHARS)))
        else $error("string length beyond capacity");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == DP_CLEAR) |=> (r_nlen == '0) && (r_plen == '0) && !r_ovf)
        else $error("stores not cleared after match");

    a_adv_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == DP_ADV) |-> (r_pidx < r_plen))
        else $error("pattern walk past its length");

endmodule

[hw/rtl/swm_ctrl.sv]
module swm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  swm_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output swm_pkg::t_dp_ctl  o_ctl,
    input  swm_pkg::t_dp_stat i_stat,
    output logic              o_res_valid,
    output swm_pkg::t_res     o_res
);
    import swm_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_SCAN_RD   = 4'd2;
    localparam logic [3:0] S_SCAN_EV   = 4'd3;
    localparam logic [3:0] S_DECIDE    = 4'd4;
    localparam logic [3:0] S_PRE_RD    = 4'd5;
    localparam logic [3:0] S_PRE_EV    = 4'd6;
    localparam logic [3:0] S_SUF_INIT  = 4'd7;
    localparam logic [3:0] S_SUF_RD    = 4'd8;
    localparam logic [3:0] S_SUF_EV    = 4'd9;
    localparam logic [3:0] S_SKIP_TEST = 4'd10;
    localparam logic [3:0] S_SKIP_RD   = 4'd11;
    localparam logic [3:0] S_SKIP_EV   = 4'd12;
    localparam logic [3:0] S_CMP_RD    = 4'd13;
    localparam logic [3:0] S_CMP_EV    = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_res_valid;
    t_res       r_res;
    logic       fin, fin_match, fin_status;

    always_comb begin
        n_state    = r_state;
        o_ctl.op   = DP_NOP;
        o_ctl.wdata = i_cmd.char_value;
        fin        = 1'b0;
        fin_match  = 1'b0;
        fin_status = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.operation)
                        OP_APPEND_NAME: o_ctl.op = DP_APP_NAME;
                        OP_APPEND_PAT:  o_ctl.op = DP_APP_PAT;
                        OP_MATCH:       n_state = S_CHECK;
                        default: begin
                        end
                    endcase
                end
            end
            S_CHECK: begin
                priority if (i_stat.ovf) begin
                    fin        = 1'b1;
                    fin_status = 1'b1;
                end else if (i_stat.name_empty || i_stat.pat_empty) begin
                    fin = 1'b1;
                end else begin
                    o_ctl.op = DP_SCAN_INIT;
                    n_state  = S_SCAN_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                o_ctl.op = DP_SCAN_STEP;
                n_state  = i_stat.p_last ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE: begin
                priority if (!i_stat.have_nonstar) begin
                    fin       = 1'b1;
                    fin_match = 1'b1;
                end else if (i_stat.short_fail) begin
                    fin = 1'b1;
                end else begin
                    o_ctl.op = DP_PRE_INIT;
                    n_state  = i_stat.first_zero ? S_SUF_INIT : S_PRE_RD;
                end
            end
            S_PRE_RD: n_state = S_PRE_EV;
            S_PRE_EV: begin
                if (!i_stat.chars_eq) begin
                    fin = 1'b1;
                end else begin
                    o_ctl.op = DP_ADV;
                    n_state  = i_stat.pre_last ? S_SUF_INIT : S_PRE_RD;
                end
            end
            S_SUF_INIT: begin
                priority if (!i_stat.have_star) begin
                    fin       = 1'b1;
                    fin_match = 1'b1;
                end else if (i_stat.suf_zero) begin
                    o_ctl.op = DP_SEG_INIT;
                    n_state  = S_SKIP_TEST;
                end else begin
                    o_ctl.op = DP_SUF_INIT;
                    n_state  = S_SUF_RD;
                end
            end
            S_SUF_RD: n_state = S_SUF_EV;
            S_SUF_EV: begin
                priority if (!i_stat.chars_eq) begin
                    fin = 1'b1;
                end else if (i_stat.p_last) begin
                    o_ctl.op = DP_SEG_INIT;
                    n_state  = S_SKIP_TEST;
                end else begin
                    o_ctl.op = DP_ADV;
                    n_state  = S_SUF_RD;
                end
            end
            S_SKIP_TEST: begin
                if (i_stat.skip_done) begin
                    fin       = 1'b1;
                    fin_match = 1'b1;
                end else begin
                    n_state = S_SKIP_RD;
                end
            end
            S_SKIP_RD: n_state = S_SKIP_EV;
            S_SKIP_EV: begin
                if (i_stat.pat_star) begin
                    o_ctl.op = DP_PINC;
                    n_state  = S_SKIP_TEST;
                end else begin
                    o_ctl.op = DP_SEG_START;
                    n_state  = S_CMP_RD;
                end
            end
            S_CMP_RD: n_state = S_CMP_EV;
            S_CMP_EV: begin
                priority if (i_stat.pat_star) begin
                    o_ctl.op = DP_SEG_DONE;
                    n_state  = S_SKIP_TEST;
                end else if (i_stat.at_hi) begin
                    fin = 1'b1;
                end else if (i_stat.chars_eq) begin
                    o_ctl.op = DP_ADV;
                    n_state  = S_CMP_RD;
                end else begin
                    o_ctl.op = DP_RETRY;
                    n_state  = S_CMP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (fin) begin
            o_ctl.op = DP_CLEAR;
            n_state  = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_res.matched <= fin_match;
            r_res.status  <= fin_status;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_res_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $past(r_state != S_IDLE))
        else $error("result without a match walk");

    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("result strobe longer than one cycle");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.status) |-> !r_res.matched)
        else $error("match reported together with overflow");

endmodule

[hw/rtl/star_wildcard_match_top.sv]
// star-only wildcard matcher
//
// command channel: an item transfers on a rising edge with i_start high and o_busy low.
// i_cmd.operation selects append to the name store, append to the pattern store,
// or match. appends never raise o_busy, so while no match is running characters can
// stream in at one per cycle; an append to a full store is dropped and sets overflow.
// a match raises o_busy while a controller walks both stores, then emits exactly one
// result on o_result with o_result_valid high for one cycle and clears both stores.
// the result strobe comes in the first cycle o_busy is low again, so the next command
// may transfer in that same cycle. the receiver cannot stall: it takes the result then.
// a match first checks overflow and empty strings, then scans the pattern for stars,
// then compares the prefix, the suffix and the segments between stars. each compare
// uses a read state and an evaluate state because each store has one registered read
// port. segment search retries each start position, so the worst case grows with
// name length times segment length.
// reset clears both lengths, the overflow flag and the controller; store contents
// are not cleared and need not be.
module star_wildcard_match_top #(
    parameter int MAX_CHARS = swm_pkg::MAX_CHARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  swm_pkg::t_cmd i_cmd,
    output logic          o_busy,
    output logic          o_result_valid,
    output swm_pkg::t_res o_result
);
    import swm_pkg::*;

    // command and status between sequencer and datapath
    t_dp_ctl  dp_ctl;
    t_dp_stat dp_stat;

    // sequencer: command decode, match walk, result register
    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_ctl       (dp_ctl),
        .i_stat      (dp_stat),
        .o_res_valid (o_result_valid),
        .o_res       (o_result)
    );

    // datapath: both character stores, lengths, walk indexes and compares
    swm_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dp_ctl),
        .o_stat  (dp_stat)
    );

endmodule
